>>> sv/utf8vs_pkg.sv
`timescale 1ns / 1ps

package utf8vs_pkg;

	localparam logic [7:0]  QMARK       = 8'h3F;
	localparam logic [7:0]  LEAD_MIN    = 8'hC2;
	localparam logic [7:0]  LEAD_MAX    = 8'hF4;
	localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
	localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
	localparam logic [20:0] CP_LIMIT    = 21'h110000;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00E000;
	localparam logic [20:0] FLOOR3      = 21'h000800;
	localparam logic [20:0] FLOOR4      = 21'h010000;
	localparam logic [1:0]  CONT_TAG    = 2'b10;

	localparam int unsigned QUEUE_DEPTH = 4;

	// One entry of the queue: a run of held bytes (originals or all '?'),
	// then an optional closing result.
	typedef struct packed {
		logic [1:0]       pre_n;
		logic             pre_bad;
		logic [2:0][7:0]  pre_bytes;
		logic             tail_v;
		logic [7:0]       tail_byte;
		logic             tail_rep;
		logic             tail_done;
		logic [20:0]      tail_cp;
		logic             tail_end;
		logic             tail_clean;
	} cmd_t;

endpackage

>>> sv/utf8_validate_sanitize.sv
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+--------------------------------------------
// input   | in_valid / in_stall  | in_byte
// output  | out_valid / out_stall| out_byte, replaced, char_done, code_point,
//         |                      | string_end, string_clean, last
//
// One byte is taken per cycle while the queue is not full; the decoder answers in the same cycle it takes a byte.
// Each queue entry is played out at one result per cycle while out_stall allows, 1 to 4 results per entry.
// The first result of a byte is registered in the queue and then in the output register.
// The output port limits throughput.
// in_stall rises only while the command queue is full; out_stall holds the output register.
// Reset clears the decoder state, the queue and the output valid.

module utf8_validate_sanitize #(
	parameter int unsigned QDEPTH = utf8vs_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        replaced,
	output logic        char_done,
	output logic [20:0] code_point,
	output logic        string_end,
	output logic        string_clean,
	output logic        last
);
	import utf8vs_pkg::*;

	cmd_t cmd;
	cmd_t head;
	logic push, pop, full, empty;

	utf8vs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.full     (full),
		.in_stall (in_stall),
		.push     (push),
		.cmd      (cmd)
	);

	utf8vs_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	utf8vs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.replaced     (replaced),
		.char_done    (char_done),
		.code_point   (code_point),
		.string_end   (string_end),
		.string_clean (string_clean),
		.last         (last)
	);

endmodule

>>> sv/utf8vs_front.sv
`timescale 1ns / 1ps

module utf8vs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                full,
	output logic                in_stall,
	output logic                push,
	output utf8vs_pkg::cmd_t    cmd
);
	import utf8vs_pkg::*;

	logic [2:0][7:0] held_q, held_nxt;
	logic [1:0]      held_cnt_q, held_cnt_nxt;
	logic [2:0]      seq_len_q, seq_len_nxt;
	logic [20:0]     part_q, part_nxt;
	logic            any_rep_q, any_rep_nxt;

	logic            accept;
	logic            is_cont;
	logic            start;
	logic [1:0]      k;
	logic [2:0]      rem;
	logic [20:0]     new_part;
	logic [20:0]     c_bits;
	logic            incons;
	logic            fail;

	assign accept   = in_valid && !full;
	assign in_stall = full;
	assign is_cont  = (in_byte[7:6] == CONT_TAG);
	assign k        = held_cnt_q;
	assign rem      = seq_len_q - 3'd1 - {1'b0, k};
	assign c_bits   = {15'd0, in_byte[5:0]};

	always_comb begin
		unique case (rem)
			3'd0:    new_part = part_q | c_bits;
			3'd1:    new_part = part_q | (c_bits << 6);
			default: new_part = part_q | (c_bits << 12);
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.pre_bytes = held_q;
		held_nxt     = held_q;
		held_cnt_nxt = held_cnt_q;
		seq_len_nxt  = seq_len_q;
		part_nxt     = part_q;
		any_rep_nxt  = any_rep_q;
		start        = 1'b0;
		incons       = (k == 2'd0) || ({1'b0, k} >= seq_len_q);
		fail         = 1'b0;

		if (seq_len_q == 3'd0) begin
			start = 1'b1;
		end else if (is_cont) begin
			if (seq_len_q == 3'd4 && k == 2'd1 && new_part >= CP_LIMIT)
				fail = 1'b1;
			if (seq_len_q == 3'd4 && k == 2'd2) begin
				if ((new_part >= SURR_LO && new_part < SURR_HI) || new_part < FLOOR4)
					fail = 1'b1;
			end
			if (seq_len_q == 3'd3 && k == 2'd1) begin
				if ((new_part >= SURR_LO && new_part < SURR_HI) || new_part < FLOOR3)
					fail = 1'b1;
			end
			if (incons || fail) begin
				// drop the sequence: held bytes and this one become '?'
				cmd.pre_n    = k;
				cmd.pre_bad  = 1'b1;
				cmd.tail_v   = 1'b1;
				cmd.tail_byte = QMARK;
				cmd.tail_rep = 1'b1;
				any_rep_nxt  = 1'b1;
				held_cnt_nxt = 2'd0;
				seq_len_nxt  = 3'd0;
				part_nxt     = '0;
			end else if ({1'b0, k} + 3'd1 == seq_len_q) begin
				cmd.pre_n     = k;
				cmd.tail_v    = 1'b1;
				cmd.tail_byte = in_byte;
				cmd.tail_done = 1'b1;
				cmd.tail_cp   = new_part;
				held_cnt_nxt  = 2'd0;
				seq_len_nxt   = 3'd0;
				part_nxt      = '0;
			end else begin
				if (k != 2'd3)
					held_nxt[k] = in_byte;
				held_cnt_nxt = k + 2'd1;
				part_nxt     = new_part;
			end
		end else begin
			// broken sequence: flush held bytes, then restart on this byte
			cmd.pre_n    = k;
			cmd.pre_bad  = 1'b1;
			if (k != 2'd0)
				any_rep_nxt = 1'b1;
			held_cnt_nxt = 2'd0;
			seq_len_nxt  = 3'd0;
			part_nxt     = '0;
			start        = 1'b1;
		end

		if (start) begin
			priority if (in_byte == 8'd0) begin
				cmd.tail_v     = 1'b1;
				cmd.tail_end   = 1'b1;
				cmd.tail_clean = !any_rep_nxt;
				any_rep_nxt    = 1'b0;
			end else if (!in_byte[7]) begin
				cmd.tail_v    = 1'b1;
				cmd.tail_byte = in_byte;
				cmd.tail_done = 1'b1;
				cmd.tail_cp   = {13'd0, in_byte};
			end else if (in_byte > LEAD_MAX || is_cont || in_byte < LEAD_MIN) begin
				cmd.tail_v    = 1'b1;
				cmd.tail_byte = QMARK;
				cmd.tail_rep  = 1'b1;
				any_rep_nxt   = 1'b1;
			end else if (in_byte >= LEAD4_MIN) begin
				seq_len_nxt  = 3'd4;
				part_nxt     = {in_byte[2:0], 18'd0};
				held_nxt[0]  = in_byte;
				held_cnt_nxt = 2'd1;
			end else if (in_byte >= LEAD3_MIN) begin
				seq_len_nxt  = 3'd3;
				part_nxt     = {5'd0, in_byte[3:0], 12'd0};
				held_nxt[0]  = in_byte;
				held_cnt_nxt = 2'd1;
			end else begin
				seq_len_nxt  = 3'd2;
				part_nxt     = {10'd0, in_byte[4:0], 6'd0};
				held_nxt[0]  = in_byte;
				held_cnt_nxt = 2'd1;
			end
		end
	end

	assign push = accept && ((cmd.pre_n != 2'd0) || cmd.tail_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= '0;
			seq_len_q  <= '0;
			part_q     <= '0;
			any_rep_q  <= 1'b0;
		end else if (accept) begin
			held_q     <= held_nxt;
			held_cnt_q <= held_cnt_nxt;
			seq_len_q  <= seq_len_nxt;
			part_q     <= part_nxt;
			any_rep_q  <= any_rep_nxt;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q == 3'd0 |-> held_cnt_q == 2'd0)
		else $error("held bytes while no sequence is open");

	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q != 3'd0 |-> held_cnt_q != 2'd0 && {1'b0, held_cnt_q} < seq_len_q)
		else $error("held count out of step with sequence length");

endmodule

>>> sv/utf8vs_queue.sv
`timescale 1ns / 1ps

module utf8vs_queue #(
	parameter int unsigned QDEPTH = utf8vs_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utf8vs_pkg::cmd_t    wr_cmd,
	input  logic                pop,
	output utf8vs_pkg::cmd_t    head,
	output logic                full,
	output logic                empty
);
	import utf8vs_pkg::*;

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head  = mem_q[rd_ptr_q];
	assign full  = (cnt_q == CNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

endmodule

>>> sv/utf8vs_back.sv
`timescale 1ns / 1ps

module utf8vs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8vs_pkg::cmd_t    head,
	input  logic                empty,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                replaced,
	output logic                char_done,
	output logic [20:0]         code_point,
	output logic                string_end,
	output logic                string_clean,
	output logic                last
);
	import utf8vs_pkg::*;

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        replaced_q, char_done_q, string_end_q, string_clean_q, last_q;
	logic [20:0] code_point_q;

	logic        load;
	logic        in_pre;
	logic        is_last;
	logic [2:0]  total;
	logic [7:0]  r_byte;
	logic        r_rep, r_done, r_end, r_clean;
	logic [20:0] r_cp;

	assign load    = !empty && (!out_valid_q || !out_stall);
	assign total   = {1'b0, head.pre_n} + {2'b00, head.tail_v};
	assign is_last = ({1'b0, idx_q} + 3'd1 == total);
	assign in_pre  = (idx_q < head.pre_n);
	assign pop     = load && is_last;

	always_comb begin
		if (in_pre) begin
			r_byte  = head.pre_bad ? QMARK : head.pre_bytes[idx_q];
			r_rep   = head.pre_bad;
			r_done  = 1'b0;
			r_cp    = '0;
			r_end   = 1'b0;
			r_clean = 1'b0;
		end else begin
			r_byte  = head.tail_byte;
			r_rep   = head.tail_rep;
			r_done  = head.tail_done;
			r_cp    = head.tail_cp;
			r_end   = head.tail_end;
			r_clean = head.tail_clean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= r_byte;
			replaced_q     <= r_rep;
			char_done_q    <= r_done;
			code_point_q   <= r_cp;
			string_end_q   <= r_end;
			string_clean_q <= r_clean;
			last_q         <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign replaced     = replaced_q;
	assign char_done    = char_done_q;
	assign code_point   = code_point_q;
	assign string_end   = string_end_q;
	assign string_clean = string_clean_q;
	assign last         = last_q;

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> total != 3'd0 && {1'b0, idx_q} < total)
		else $error("queue entry has no result at the current index");

	a_qmark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && replaced_q |-> out_byte_q == QMARK && !char_done_q)
		else $error("replaced result is not a plain question mark");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import utf8vs_pkg::*;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        replaced;
		logic        char_done;
		logic [20:0] code_point;
		logic        string_end;
		logic        string_clean;
		logic        last;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        replaced;
	logic        char_done;
	logic [20:0] code_point;
	logic        string_end;
	logic        string_clean;
	logic        last;

	utf8_validate_sanitize i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.replaced(replaced),
		.char_done(char_done),
		.code_point(code_point),
		.string_end(string_end),
		.string_clean(string_clean),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state of the predictor
	logic [7:0]  dec_held [3];
	int          dec_count;
	int          dec_len;
	logic [20:0] dec_code;
	logic        dec_dirty;

	res_t step_q[$];
	res_t sanitized_q[$];
	int   text_q[$];          // bytes still to send; a negative entry waits for a drain

	int n_planned;
	int n_in;
	int n_out;
	int n_chars;
	int n_qmarks;
	int n_strings;
	int n_bad;

	logic       took_in = 1'b0;
	int         gap_left;
	int         stall_left;
	int         hold_left;
	int         hold_at = 40;
	logic       next_valid;
	logic [7:0] next_byte;

	task automatic add_res(input logic [7:0] b, input logic rep, input logic done,
			input logic [20:0] cp, input logic send, input logic clean);
		res_t r;
		r.out_byte = b;
		r.replaced = rep;
		r.char_done = done;
		r.code_point = done ? cp : 21'd0;
		r.string_end = send;
		r.string_clean = send ? clean : 1'b0;
		r.last = 1'b0;
		if (step_q.size() < 4)
			step_q.push_back(r);
	endtask

	task automatic add_bad();
		add_res(QMARK, 1'b1, 1'b0, 21'd0, 1'b0, 1'b0);
		dec_dirty = 1'b1;
	endtask

	task automatic go_idle();
		dec_count = 0;
		dec_len = 0;
		dec_code = 21'd0;
	endtask

	task automatic flush_bad();
		for (int i = 0; i < dec_count && i < 3; i++)
			add_bad();
		go_idle();
	endtask

	task automatic start_seq(input logic [7:0] c);
		if (c == 8'h00) begin
			add_res(8'h00, 1'b0, 1'b0, 21'd0, 1'b1, !dec_dirty);
			dec_dirty = 1'b0;
		end else if (c < 8'h80) begin
			add_res(c, 1'b0, 1'b1, {13'd0, c}, 1'b0, 1'b0);
		end else if (c > LEAD_MAX || c[7:6] == CONT_TAG || c < LEAD_MIN) begin
			add_bad();
		end else begin
			if (c >= LEAD4_MIN) begin
				dec_len = 4;
				dec_code = {c[2:0], 18'd0};
			end else if (c >= LEAD3_MIN) begin
				dec_len = 3;
				dec_code = {5'd0, c[3:0], 12'd0};
			end else begin
				dec_len = 2;
				dec_code = {10'd0, c[4:0], 6'd0};
			end
			dec_held[0] = c;
			dec_count = 1;
		end
	endtask

	task automatic take_cont(input logic [7:0] c);
		int k;
		int shift;
		logic fail;
		logic [20:0] lower;
		k = dec_count;
		fail = 1'b0;
		if (k == 0 || k >= dec_len || k > 3) begin
			flush_bad();
			add_bad();
			return;
		end
		shift = 6 * (dec_len - 1 - k);
		dec_code = 21'(32'(dec_code) | (32'(c[5:0]) << shift));
		if (dec_len == 4 && k == 1 && dec_code >= CP_LIMIT)
			fail = 1'b1;
		if ((dec_len == 4 && k == 2) || (dec_len == 3 && k == 1)) begin
			lower = (dec_len == 4) ? FLOOR4 : FLOOR3;
			if (dec_code >= SURR_LO && dec_code < SURR_HI)
				fail = 1'b1;
			if (dec_code < lower)
				fail = 1'b1;
		end
		if (fail) begin
			flush_bad();
			add_bad();
			return;
		end
		if (k + 1 == dec_len) begin
			for (int i = 0; i < dec_count && i < 3; i++)
				add_res(dec_held[i], 1'b0, 1'b0, 21'd0, 1'b0, 1'b0);
			add_res(c, 1'b0, 1'b1, dec_code, 1'b0, 1'b0);
			go_idle();
			return;
		end
		dec_held[k] = c;
		dec_count = k + 1;
	endtask

	task automatic decode_byte(input logic [7:0] c);
		res_t r;
		step_q.delete();
		if (dec_len == 0)
			start_seq(c);
		else if (c[7:6] == CONT_TAG)
			take_cont(c);
		else begin
			flush_bad();
			start_seq(c);
		end
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.last = 1'b1;
			step_q.push_back(r);
		end
		for (int i = 0; i < step_q.size(); i++)
			sanitized_q.push_back(step_q[i]);
	endtask

	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic quiet_phase();
		return n_in >= 150 && n_in < 220;
	endfunction

	task automatic push_byte(input int b);
		text_q.push_back(b & 8'hFF);
		n_planned++;
	endtask

	task automatic push_utf8(input int cp);
		if (cp < 'h80) begin
			push_byte(cp);
		end else if (cp < 'h800) begin
			push_byte('hC0 | (cp >> 6));
			push_byte('h80 | (cp & 'h3F));
		end else if (cp < 'h10000) begin
			push_byte('hE0 | (cp >> 12));
			push_byte('h80 | ((cp >> 6) & 'h3F));
			push_byte('h80 | (cp & 'h3F));
		end else begin
			push_byte('hF0 | (cp >> 18));
			push_byte('h80 | ((cp >> 12) & 'h3F));
			push_byte('h80 | ((cp >> 6) & 'h3F));
			push_byte('h80 | (cp & 'h3F));
		end
	endtask

	task automatic push_malformed();
		case ($urandom_range(0, 5))
			0: push_byte($urandom_range('h80, 'hBF));
			1: begin
				if ($urandom_range(0, 1))
					push_byte($urandom_range('hC0, 'hC1));
				else
					push_byte($urandom_range('hF5, 'hFF));
				push_byte($urandom_range('h80, 'hBF));
			end
			2: begin
				push_byte('hE0);
				push_byte($urandom_range('h80, 'h9F));
				push_byte($urandom_range('h80, 'hBF));
			end
			3: begin
				push_byte('hED);
				push_byte($urandom_range('hA0, 'hBF));
				push_byte($urandom_range('h80, 'hBF));
			end
			4: begin
				push_byte('hF0);
				push_byte($urandom_range('h80, 'h8F));
				push_byte($urandom_range('h80, 'hBF));
				push_byte($urandom_range('h80, 'hBF));
			end
			default: begin
				push_byte('hF4);
				push_byte($urandom_range('h90, 'hBF));
				push_byte($urandom_range('h80, 'hBF));
				push_byte($urandom_range('h80, 'hBF));
			end
		endcase
	endtask

	// sample and check at the rising edge
	always @(posedge clk) begin
		res_t got;
		res_t want;
		took_in <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			decode_byte(in_byte);
			n_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {out_byte, replaced, char_done, code_point, string_end, string_clean, last};
			n_out++;
			n_chars += char_done;
			n_qmarks += replaced;
			n_strings += string_end;
			if (sanitized_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: unexpected byte=%h rep=%b done=%b cp=%h end=%b clean=%b last=%b",
						$realtime, got.out_byte, got.replaced, got.char_done,
						got.code_point, got.string_end, got.string_clean, got.last);
			end else begin
				want = sanitized_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("%0t: mismatch exp byte=%h rep=%b done=%b cp=%h end=%b clean=%b last=%b",
							$realtime, want.out_byte, want.replaced, want.char_done,
							want.code_point, want.string_end, want.string_clean, want.last);
						$display("%0t:          got byte=%h rep=%b done=%b cp=%h end=%b clean=%b last=%b",
							$realtime, got.out_byte, got.replaced, got.char_done,
							got.code_point, got.string_end, got.string_clean, got.last);
					end
				end
			end
		end
	end

	// sender: hold a stalled item, otherwise advance after the gap
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took_in)) begin
			next_valid = 1'b0;
			next_byte = in_byte;
			if (gap_left > 0) begin
				gap_left--;
			end else if (text_q.size() > 0) begin
				if (text_q[0] < 0) begin
					if (sanitized_q.size() == 0)
						void'(text_q.pop_front());
				end else begin
					next_valid = 1'b1;
					next_byte = text_q.pop_front();
					gap_left = quiet_phase() ? 0 : draw_idle();
				end
			end
			in_valid <= next_valid;
			in_byte <= next_byte;
		end
	end

	// receiver: random stalls plus two long hold-offs to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_in >= hold_at) begin
				hold_left = 80;
				hold_at = (hold_at < 300) ? 300 : 32'h7FFF_FFFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = quiet_phase() ? 0 : draw_idle();
			end
		end
	end

	initial begin
		logic [7:0] directed [25];
		int r;
		int len_before;
		logic drained_mid;

		directed = '{8'h41, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0,
			8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'hF0, 8'h8F, 8'h80, 8'hC1,
			8'hF5, 8'h80, 8'hE2, 8'h82, 8'h00, 8'h00};
		dec_dirty = 1'b0;
		go_idle();
		for (int i = 0; i < 3; i++)
			dec_held[i] = 8'h00;
		for (int i = 0; i < 25; i++)
			push_byte(directed[i]);
		text_q.push_back(-1);

		drained_mid = 1'b0;
		while (n_planned < 405) begin
			r = $urandom_range(0, 99);
			if (r < 28)
				push_byte($urandom_range(1, 'h7F));
			else if (r < 42)
				push_utf8($urandom_range('h80, 'h7FF));
			else if (r < 55) begin
				r = $urandom_range('h800, 'hFFFF);
				if (r >= 'hD800 && r < 'hE000)
					r = r ^ 'h2000;
				push_utf8(r);
			end else if (r < 65)
				push_utf8($urandom_range('h10000, 'h10FFFF));
			else if (r < 70)
				push_byte(0);
			else if (r < 78) begin
				// drop the final byte of a multibyte character
				len_before = text_q.size();
				push_utf8($urandom_range('h80, 'h10FFFF));
				if (text_q.size() - len_before > 1) begin
					void'(text_q.pop_back());
					n_planned--;
				end
			end else if (r < 92)
				push_malformed();
			else
				push_byte($urandom_range(0, 255));
			if (!drained_mid && n_planned >= 250) begin
				text_q.push_back(-1);
				drained_mid = 1'b1;
			end
		end
		push_byte(0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_q.size() > 0 || in_valid)
			@(posedge clk);
		while (sanitized_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		n_bad += sanitized_q.size();

		$display("Sent %0d bytes, checked %0d results:", n_in, n_out);
		$display("%0d characters, %0d substitutions, %0d strings.",
			n_chars, n_qmarks, n_strings);
		if (n_bad == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding", sanitized_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/utf8vs_pkg.sv
sv/utf8vs_front.sv
sv/utf8vs_queue.sv
sv/utf8vs_back.sv
sv/utf8_validate_sanitize.sv
verif/tb.sv
